// ===== sv/lpi_pkg.sv =====
`default_nettype none
package lpi_pkg;
	localparam int CW = 32;
	localparam int DW = CW + 1;          // difference width
	localparam int PW = 2 * DW;          // product width
	localparam int SW = PW + 2;          // sum of three products
	localparam int HW = SW / 2;          // half of the numerator width
	localparam int TW = DW + SW;         // d * num width
	localparam int QSTEPS = TW;          // quotient bits

	typedef logic signed [CW-1:0] coord_t;

	typedef enum logic [2:0] {
		REG_NORMAL_X = 3'd0,
		REG_NORMAL_Y = 3'd1,
		REG_NORMAL_Z = 3'd2,
		REG_ANCHOR_X = 3'd3,
		REG_ANCHOR_Y = 3'd4,
		REG_ANCHOR_Z = 3'd5
	} reg_idx_t;
endpackage
`default_nettype wire

// ===== sv/line_plane_intersection.sv =====
// Pipeline depth: 110 register stages.
// Throughput: one beat per cycle; the whole pipeline advances together and holds on stall.
// The depth is set by the restoring divider, one quotient bit per stage (101 of the 110).
// Reset clears all valid bits and the plane registers to zero; data registers are not reset.
`default_nettype none
module line_plane_intersection (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [2:0] cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic signed [31:0] start_x,
	input  wire logic signed [31:0] start_y,
	input  wire logic signed [31:0] start_z,
	input  wire logic signed [31:0] end_x,
	input  wire logic signed [31:0] end_y,
	input  wire logic signed [31:0] end_z,
	output logic out_valid,
	input  wire logic out_stall,
	output logic hit,
	output logic signed [31:0] cross_x,
	output logic signed [31:0] cross_y,
	output logic signed [31:0] cross_z,
	output logic clipped
);
	import lpi_pkg::*;

	// Six front stages, the divider with its rounding stage, and two back stages.
	localparam int NS = QSTEPS + 9;

	logic signed [CW-1:0] nrm_q [3];
	logic signed [CW-1:0] anc_q [3];
	logic adv;
	logic [NS-1:0] v_s;

	// Plane registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				nrm_q[i] <= '0;
				anc_q[i] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NORMAL_X: nrm_q[0] <= cfg_data;
				REG_NORMAL_Y: nrm_q[1] <= cfg_data;
				REG_NORMAL_Z: nrm_q[2] <= cfg_data;
				REG_ANCHOR_X: anc_q[0] <= cfg_data;
				REG_ANCHOR_Y: anc_q[1] <= cfg_data;
				REG_ANCHOR_Z: anc_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Whole pipeline moves unless a finished beat is stalled.
	assign adv = !(out_valid && out_stall);
	assign in_stall = !adv;
	assign out_valid = v_s[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s <= '0;
		else if (adv) v_s <= {v_s[NS-2:0], in_valid};
	end

	// Stage 1: differences.
	logic signed [CW-1:0] s_s1 [3];
	logic signed [DW-1:0] d_s1 [3], a_s1 [3];
	logic signed [CW-1:0] n_s1 [3];
	// Stage 2: products.
	logic signed [CW-1:0] s_s2 [3];
	logic signed [DW-1:0] d_s2 [3];
	logic signed [PW-1:0] pn_s2 [3], pd_s2 [3];
	// Stage 3: sums.
	logic signed [CW-1:0] s_s3 [3];
	logic signed [DW-1:0] d_s3 [3];
	logic signed [SW-1:0] num_s3, den_s3;
	// Stage 4: magnitudes and signs.
	logic signed [CW-1:0] s_s4 [3];
	logic [DW-1:0] md_s4 [3];
	logic [SW-1:0] mn_s4;
	logic [SW-1:0] den_s4;
	logic [2:0] neg_s4;
	logic hit_s4;
	// Stage 5: partial products of |d| * |num| on the two halves of |num|.
	logic signed [CW-1:0] s_s5 [3];
	logic [DW+HW-1:0] pl_s5 [3], ph_s5 [3];
	logic [SW-1:0] den_s5;
	logic [2:0] neg_s5;
	logic hit_s5;
	// Stage 6: full dividend magnitudes.
	logic signed [CW-1:0] s_s6 [3];
	logic [TW-1:0] t_s6 [3];
	logic [SW-1:0] den_s6;
	logic [2:0] neg_s6;
	logic hit_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				s_s1[k] <= k == 0 ? start_x : (k == 1 ? start_y : start_z);
				n_s1[k] <= nrm_q[k];
			end
			d_s1[0] <= DW'(end_x) - DW'(start_x);
			d_s1[1] <= DW'(end_y) - DW'(start_y);
			d_s1[2] <= DW'(end_z) - DW'(start_z);
			a_s1[0] <= DW'(anc_q[0]) - DW'(start_x);
			a_s1[1] <= DW'(anc_q[1]) - DW'(start_y);
			a_s1[2] <= DW'(anc_q[2]) - DW'(start_z);
			for (int k = 0; k < 3; k++) begin
				s_s2[k] <= s_s1[k];
				d_s2[k] <= d_s1[k];
				pn_s2[k] <= PW'(a_s1[k]) * PW'(n_s1[k]);
				pd_s2[k] <= PW'(d_s1[k]) * PW'(n_s1[k]);
				s_s3[k] <= s_s2[k];
				d_s3[k] <= d_s2[k];
			end
			num_s3 <= SW'(pn_s2[0]) + SW'(pn_s2[1]) + SW'(pn_s2[2]);
			den_s3 <= SW'(pd_s2[0]) + SW'(pd_s2[1]) + SW'(pd_s2[2]);
			// The sign of each quotient comes from d, num and den.
			for (int k = 0; k < 3; k++) begin
				s_s4[k] <= s_s3[k];
				md_s4[k] <= d_s3[k][DW-1] ? -d_s3[k] : d_s3[k];
				neg_s4[k] <= d_s3[k][DW-1] ^ num_s3[SW-1] ^ den_s3[SW-1];
			end
			mn_s4 <= num_s3[SW-1] ? -num_s3 : num_s3;
			den_s4 <= den_s3[SW-1] ? -den_s3 : den_s3;
			hit_s4 <= den_s3 != '0;
			for (int k = 0; k < 3; k++) begin
				s_s5[k] <= s_s4[k];
				pl_s5[k] <= (DW+HW)'(md_s4[k]) * (DW+HW)'(mn_s4[HW-1:0]);
				ph_s5[k] <= (DW+HW)'(md_s4[k]) * (DW+HW)'(mn_s4[SW-1:HW]);
			end
			den_s5 <= den_s4;
			neg_s5 <= neg_s4;
			hit_s5 <= hit_s4;
			for (int k = 0; k < 3; k++) begin
				s_s6[k] <= s_s5[k];
				t_s6[k] <= (TW'(ph_s5[k]) << HW) + TW'(pl_s5[k]);
			end
			den_s6 <= den_s5;
			neg_s6 <= neg_s5;
			hit_s6 <= hit_s5;
		end
	end

	// Divider lanes.
	logic [TW-1:0] q_d [3];
	logic signed [CW-1:0] s_d [3];
	logic [2:0] neg_d;
	logic hit_d;
	logic [2:0] rnd_d;

	lpi_div u_div (
		.clk(clk), .adv(adv),
		.t_in(t_s6), .den_in(den_s6), .s_in(s_s6), .neg_in(neg_s6), .hit_in(hit_s6),
		.q_out(q_d), .s_out(s_d), .neg_out(neg_d), .hit_out(hit_d), .rnd_out(rnd_d)
	);

	// Rounding and sign: -(q + r) is formed as ~q + (1 - r).
	logic signed [TW+1:0] qs_s7 [3];
	logic signed [CW-1:0] s_s7 [3];
	logic hit_s7;
	always_ff @(posedge clk) begin
		if (adv) begin
			logic [TW+1:0] qm;
			for (int k = 0; k < 3; k++) begin
				qm = {2'b00, q_d[k]};
				qs_s7[k] <= neg_d[k] ? $signed(~qm + (TW+2)'(!rnd_d[k]))
					: $signed(qm + (TW+2)'(rnd_d[k]));
				s_s7[k] <= s_d[k];
			end
			hit_s7 <= hit_d;
		end
	end

	// Offset and saturation, then output register.
	logic signed [CW-1:0] c_s [3];
	logic clip_s, hit_s;
	always_ff @(posedge clk) begin
		if (adv) begin
			logic signed [TW+1:0] v;
			logic signed [CW-1:0] cv;
			logic cl;
			cl = 1'b0;
			for (int k = 0; k < 3; k++) begin
				v = qs_s7[k] + (TW+2)'(s_s7[k]);
				if (v > (TW+2)'($signed({1'b0, {(CW-1){1'b1}}}))) begin
					cv = {1'b0, {(CW-1){1'b1}}};
					cl = 1'b1;
				end else if (v < -(TW+2)'($signed({1'b0, {(CW-1){1'b1}}})) - 1) begin
					cv = {1'b1, {(CW-1){1'b0}}};
					cl = 1'b1;
				end else cv = v[CW-1:0];
				if (!hit_s7) cv = '0;
				c_s[k] <= cv;
			end
			clip_s <= cl & hit_s7;
			hit_s <= hit_s7;
		end
	end

	assign hit = hit_s;
	assign cross_x = c_s[0];
	assign cross_y = c_s[1];
	assign cross_z = c_s[2];
	assign clipped = clip_s;
endmodule

// Restoring divider, one quotient bit per stage, three lanes sharing one divisor.
// The dividend shifts out of the top of dq while quotient bits shift in at the bottom.
// A last stage registers the quotient and whether the remainder is at least half the divisor.
module lpi_div (
	input  wire logic clk,
	input  wire logic adv,
	input  wire logic [lpi_pkg::TW-1:0] t_in [3],
	input  wire logic [lpi_pkg::SW-1:0] den_in,
	input  wire logic signed [lpi_pkg::CW-1:0] s_in [3],
	input  wire logic [2:0] neg_in,
	input  wire logic hit_in,
	output logic [lpi_pkg::TW-1:0] q_out [3],
	output logic signed [lpi_pkg::CW-1:0] s_out [3],
	output logic [2:0] neg_out,
	output logic hit_out,
	output logic [2:0] rnd_out
);
	import lpi_pkg::*;

	logic [SW-1:0] rem_s [QSTEPS][3];
	logic [TW-1:0] dq_s [QSTEPS][3];
	logic [SW-1:0] den_s [QSTEPS];
	logic signed [CW-1:0] crd_s [QSTEPS][3];
	logic [2:0] neg_s [QSTEPS];
	logic hit_s [QSTEPS];

	// One compare and subtract; returns the new remainder and the shifted dq.
	function automatic logic [SW+TW-1:0] div_step(input logic [SW-1:0] rem,
		input logic [TW-1:0] dq, input logic [SW-1:0] den);
		logic [SW:0] trial;
		logic [SW:0] diff;
		trial = {rem, dq[TW-1]};
		diff = trial - {1'b0, den};
		if (diff[SW]) return {trial[SW-1:0], dq[TW-2:0], 1'b0};
		return {diff[SW-1:0], dq[TW-2:0], 1'b1};
	endfunction

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				{rem_s[0][k], dq_s[0][k]} <= div_step('0, t_in[k], den_in);
				crd_s[0][k] <= s_in[k];
			end
			den_s[0] <= den_in;
			neg_s[0] <= neg_in;
			hit_s[0] <= hit_in;
			for (int i = 1; i < QSTEPS; i++) begin
				for (int k = 0; k < 3; k++) begin
					{rem_s[i][k], dq_s[i][k]} <= div_step(rem_s[i-1][k], dq_s[i-1][k],
						den_s[i-1]);
					crd_s[i][k] <= crd_s[i-1][k];
				end
				den_s[i] <= den_s[i-1];
				neg_s[i] <= neg_s[i-1];
				hit_s[i] <= hit_s[i-1];
			end
			// Round half away from zero on the magnitude.
			for (int k = 0; k < 3; k++) begin
				q_out[k] <= dq_s[QSTEPS-1][k];
				rnd_out[k] <= {rem_s[QSTEPS-1][k], 1'b0} >= {1'b0, den_s[QSTEPS-1]};
				s_out[k] <= crd_s[QSTEPS-1][k];
			end
			neg_out <= neg_s[QSTEPS-1];
			hit_out <= hit_s[QSTEPS-1];
		end
	end
endmodule
`default_nettype wire
